/* sv/pen_axes_pkg.sv */
// types, constants and the sine table shared by the pen axes datapath
package pen_axes_pkg;

    localparam int unsigned AddrWidth  = 5;
    localparam int unsigned DataWidth  = 32;
    localparam int unsigned InWidth    = 88;
    localparam int unsigned OutWidth   = 80;
    localparam int unsigned TiltSteps  = 91;

    localparam logic [30:0]        OrientLimitSq = 31'd144000000;
    localparam logic [16:0]        OrientUnit    = 17'd10000;
    localparam logic signed [15:0] HeightTop     = 16'sd300;
    localparam logic signed [15:0] HeightBottom  = -16'sd5200;
    localparam logic [6:0]         TiltMax       = 7'd90;
    localparam logic [10:0]        PressFull     = 11'd1024;

    // register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_X_LOW    = 3'd0,
        REG_X_HIGH   = 3'd1,
        REG_Y_LOW    = 3'd2,
        REG_Y_HIGH   = 3'd3,
        REG_SWAP     = 3'd4,
        REG_MIRROR_X = 3'd5,
        REG_MIRROR_Y = 3'd6,
        REG_NONE     = 3'd7
    } reg_index_t;

    // sine of each whole degree times 10000, rounded
    localparam logic [13:0] SINE_TABLE [0:90] = '{
        14'd0,    14'd175,  14'd349,  14'd523,  14'd698,  14'd872,  14'd1045, 14'd1219,
        14'd1392, 14'd1564, 14'd1736, 14'd1908, 14'd2079, 14'd2250, 14'd2419, 14'd2588,
        14'd2756, 14'd2924, 14'd3090, 14'd3256, 14'd3420, 14'd3584, 14'd3746, 14'd3907,
        14'd4067, 14'd4226, 14'd4384, 14'd4540, 14'd4695, 14'd4848, 14'd5000, 14'd5150,
        14'd5299, 14'd5446, 14'd5592, 14'd5736, 14'd5878, 14'd6018, 14'd6157, 14'd6293,
        14'd6428, 14'd6561, 14'd6691, 14'd6820, 14'd6947, 14'd7071, 14'd7193, 14'd7314,
        14'd7431, 14'd7547, 14'd7660, 14'd7771, 14'd7880, 14'd7986, 14'd8090, 14'd8192,
        14'd8290, 14'd8387, 14'd8480, 14'd8572, 14'd8660, 14'd8746, 14'd8829, 14'd8910,
        14'd8988, 14'd9063, 14'd9135, 14'd9205, 14'd9272, 14'd9336, 14'd9397, 14'd9455,
        14'd9511, 14'd9563, 14'd9613, 14'd9659, 14'd9703, 14'd9744, 14'd9781, 14'd9816,
        14'd9848, 14'd9877, 14'd9903, 14'd9925, 14'd9945, 14'd9962, 14'd9976, 14'd9986,
        14'd9994, 14'd9998, 14'd10000
    };

    // length of the leading run of ones in a thermometer code, binary search
    function automatic logic [6:0] therm_length(input logic [TiltSteps-1:0] therm);
        logic [6:0] idx;
        logic [7:0] probe;
        idx = 7'd0;
        for (int b = 6; b >= 0; b--)
        begin
            probe = {1'b0, idx} + (8'd1 << b);
            if (probe <= 8'(TiltSteps))
            begin
                if (therm[7'(probe - 8'd1)])
                begin
                    idx = 7'(probe);
                end
            end
        end
        return idx;
    endfunction

endpackage

/* sv/pen_sample_to_tablet_axes_unit.sv */
// pen sample to tablet axes: four-stage pipeline with apb register file
// an accepted input word passes stage 1, stage 2, stage 3 and the output register to the master side
// throughput: one word per cycle; a word that fails the orientation length test
//   leaves no result; the whole pipeline stalls only while a result waits unclaimed
// reset: rst_n clears all valid bits and loads the register defaults
//   (bounds -7858/7916, -10458/10995, swap on, mirror x off, mirror y on)
module pen_sample_to_tablet_axes_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // apb register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pen_axes_pkg::AddrWidth-1:0]   paddr,
    input  logic [pen_axes_pkg::DataWidth-1:0]   pwdata,
    output logic [pen_axes_pkg::DataWidth-1:0]   prdata,
    output logic                                 pready,
    // sample words
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // raw_x[15:0] raw_y[31:16] raw_z[47:32] orient_x[63:48] orient_y[79:64] contact[80]
    input  logic [pen_axes_pkg::InWidth-1:0]     s_axis_tdata,
    // result words
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pos_x[15:0] pos_y[31:16] touching[32] pressure[43:33] distance[57:44]
    // tilt_x[65:58] tilt_y[73:66]
    output logic [pen_axes_pkg::OutWidth-1:0]    m_axis_tdata
);
    import pen_axes_pkg::*;

    // ------------------------------------------------------------------
    // register file
    // ------------------------------------------------------------------
    logic signed [15:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic               swap_reg, mirror_x_reg, mirror_y_reg;
    logic               cfg_write;
    reg_index_t         cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg    <= -16'sd7858;
            x_high_reg   <= 16'sd7916;
            y_low_reg    <= -16'sd10458;
            y_high_reg   <= 16'sd10995;
            swap_reg     <= 1'b1;
            mirror_x_reg <= 1'b0;
            mirror_y_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_X_LOW:    x_low_reg    <= pwdata[15:0];
                REG_X_HIGH:   x_high_reg   <= pwdata[15:0];
                REG_Y_LOW:    y_low_reg    <= pwdata[15:0];
                REG_Y_HIGH:   y_high_reg   <= pwdata[15:0];
                REG_SWAP:     swap_reg     <= pwdata[0];
                REG_MIRROR_X: mirror_x_reg <= pwdata[0];
                REG_MIRROR_Y: mirror_y_reg <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_X_LOW:    prdata = 32'(x_low_reg);
            REG_X_HIGH:   prdata = 32'(x_high_reg);
            REG_Y_LOW:    prdata = 32'(y_low_reg);
            REG_Y_HIGH:   prdata = 32'(y_high_reg);
            REG_SWAP:     prdata = {31'd0, swap_reg};
            REG_MIRROR_X: prdata = {31'd0, mirror_x_reg};
            REG_MIRROR_Y: prdata = {31'd0, mirror_y_reg};
            default:      prdata = '0;
        endcase
    end

    // bounds of the reported axes; the user must change the registers only while the pipe is empty (not enforced here)
    logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
    assign lo_x = swap_reg ? y_low_reg  : x_low_reg;
    assign hi_x = swap_reg ? y_high_reg : x_high_reg;
    assign lo_y = swap_reg ? x_low_reg  : y_low_reg;
    assign hi_y = swap_reg ? x_high_reg : y_high_reg;

    // ------------------------------------------------------------------
    // pipeline control: every stage moves when the output slot is free
    // ------------------------------------------------------------------
    logic advance;
    logic v1_reg, v2_reg, v3_reg;
    logic v2_next;
    logic noise;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v2_next;
            v3_reg        <= v2_reg;
            m_axis_tvalid <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: unpack, swap, magnitudes, squares
    // ------------------------------------------------------------------
    logic signed [15:0] raw_x, raw_y, raw_z, orient_x, orient_y;
    logic               contact;
    logic signed [15:0] comp_x, comp_y;
    logic signed [31:0] sq_x_full, sq_y_full;

    assign raw_x    = s_axis_tdata[15:0];
    assign raw_y    = s_axis_tdata[31:16];
    assign raw_z    = s_axis_tdata[47:32];
    assign orient_x = s_axis_tdata[63:48];
    assign orient_y = s_axis_tdata[79:64];
    assign contact  = s_axis_tdata[80];

    // tilt component feeding each reported axis
    assign comp_x    = swap_reg ? orient_y : orient_x;
    assign comp_y    = swap_reg ? orient_x : orient_y;
    assign sq_x_full = 32'(orient_x) * 32'(orient_x);
    assign sq_y_full = 32'(orient_y) * 32'(orient_y);

    logic signed [15:0] pos_x_s1_reg, pos_y_s1_reg, raw_z_s1_reg;
    logic [16:0]        mag_x_s1_reg, mag_y_s1_reg;
    logic               neg_x_s1_reg, neg_y_s1_reg, contact_s1_reg;
    logic [30:0]        sq_x_s1_reg, sq_y_s1_reg;
    logic [16:0]        mag_x_next, mag_y_next;

    // magnitude at 17 bits so the most negative code keeps its 32768
    assign mag_x_next = comp_x[15] ? 17'(-{comp_x[15], comp_x}) : {1'b0, comp_x};
    assign mag_y_next = comp_y[15] ? 17'(-{comp_y[15], comp_y}) : {1'b0, comp_y};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos_x_s1_reg   <= swap_reg ? raw_y : raw_x;
            pos_y_s1_reg   <= swap_reg ? raw_x : raw_y;
            raw_z_s1_reg   <= raw_z;
            contact_s1_reg <= contact;
            mag_x_s1_reg   <= mag_x_next;
            mag_y_s1_reg   <= mag_y_next;
            neg_x_s1_reg   <= comp_x[15];
            neg_y_s1_reg   <= comp_y[15];
            sq_x_s1_reg    <= sq_x_full[30:0];
            sq_y_s1_reg    <= sq_y_full[30:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: noise test, mirror, table compares, height clamp
    // ------------------------------------------------------------------
    logic [31:0]          len_sq;
    logic [TiltSteps-1:0] therm_x_next, therm_y_next;
    logic signed [17:0]   mir_x_next, mir_y_next;
    logic signed [13:0]   dist_next;

    assign len_sq  = {1'b0, sq_x_s1_reg} + {1'b0, sq_y_s1_reg};
    assign noise   = len_sq > {1'b0, OrientLimitSq};
    assign v2_next = v1_reg && !noise;

    // bit i set while sine(i) still falls short of the magnitude
    always_comb
    begin
        for (int i = 0; i < TiltSteps; i++)
        begin
            therm_x_next[i] = {3'd0, SINE_TABLE[i]} < mag_x_s1_reg;
            therm_y_next[i] = {3'd0, SINE_TABLE[i]} < mag_y_s1_reg;
        end
    end

    // mirror at full precision so the later clamp lands inside the bounds
    always_comb
    begin
        mir_x_next = 18'(pos_x_s1_reg);
        mir_y_next = 18'(pos_y_s1_reg);
        if (mirror_x_reg)
        begin
            mir_x_next = 18'(lo_x) + 18'(hi_x) - 18'(pos_x_s1_reg);
        end
        if (mirror_y_reg)
        begin
            mir_y_next = 18'(lo_y) + 18'(hi_y) - 18'(pos_y_s1_reg);
        end
    end

    always_comb
    begin
        if (raw_z_s1_reg < HeightBottom)
        begin
            dist_next = HeightBottom[13:0];
        end
        else if (raw_z_s1_reg > HeightTop)
        begin
            dist_next = HeightTop[13:0];
        end
        else
        begin
            dist_next = raw_z_s1_reg[13:0];
        end
    end

    logic [TiltSteps-1:0] therm_x_s2_reg, therm_y_s2_reg;
    logic                 sat_x_s2_reg, sat_y_s2_reg;
    logic                 neg_x_s2_reg, neg_y_s2_reg, contact_s2_reg;
    logic signed [17:0]   mir_x_s2_reg, mir_y_s2_reg;
    logic signed [13:0]   dist_s2_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            therm_x_s2_reg <= therm_x_next;
            therm_y_s2_reg <= therm_y_next;
            sat_x_s2_reg   <= mag_x_s1_reg >= OrientUnit;
            sat_y_s2_reg   <= mag_y_s1_reg >= OrientUnit;
            // sign of the reported tilt: component sign, flipped by mirroring
            neg_x_s2_reg   <= neg_x_s1_reg ^ mirror_x_reg;
            neg_y_s2_reg   <= neg_y_s1_reg ^ mirror_y_reg;
            mir_x_s2_reg   <= mir_x_next;
            mir_y_s2_reg   <= mir_y_next;
            dist_s2_reg    <= dist_next;
            contact_s2_reg <= contact_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: degree search, tilt sign, position clamp
    // ------------------------------------------------------------------
    logic [6:0]         deg_x, deg_y;
    logic signed [7:0]  tilt_x_next, tilt_y_next;
    logic signed [17:0] clamp_x_lo, clamp_y_lo;
    logic signed [15:0] pos_x_next, pos_y_next;

    assign deg_x = sat_x_s2_reg ? TiltMax : therm_length(therm_x_s2_reg);
    assign deg_y = sat_y_s2_reg ? TiltMax : therm_length(therm_y_s2_reg);

    assign tilt_x_next = neg_x_s2_reg ? 8'(-{1'b0, deg_x}) : {1'b0, deg_x};
    assign tilt_y_next = neg_y_s2_reg ? 8'(-{1'b0, deg_y}) : {1'b0, deg_y};

    // max with the low bound first, then min with the high bound
    assign clamp_x_lo = (mir_x_s2_reg < 18'(lo_x)) ? 18'(lo_x) : mir_x_s2_reg;
    assign clamp_y_lo = (mir_y_s2_reg < 18'(lo_y)) ? 18'(lo_y) : mir_y_s2_reg;
    assign pos_x_next = (clamp_x_lo > 18'(hi_x)) ? hi_x : clamp_x_lo[15:0];
    assign pos_y_next = (clamp_y_lo > 18'(hi_y)) ? hi_y : clamp_y_lo[15:0];

    logic signed [15:0] pos_x_s3_reg, pos_y_s3_reg;
    logic signed [7:0]  tilt_x_s3_reg, tilt_y_s3_reg;
    logic signed [13:0] dist_s3_reg;
    logic               contact_s3_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos_x_s3_reg   <= pos_x_next;
            pos_y_s3_reg   <= pos_y_next;
            tilt_x_s3_reg  <= tilt_x_next;
            tilt_y_s3_reg  <= tilt_y_next;
            dist_s3_reg    <= dist_s2_reg;
            contact_s3_reg <= contact_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_axis_tdata <= {6'd0, tilt_y_s3_reg, tilt_x_s3_reg, dist_s3_reg,
                             contact_s3_reg ? PressFull : 11'd0,
                             contact_s3_reg, pos_y_s3_reg, pos_x_s3_reg};
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a noisy sample never reaches stage 2
    a_noise_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && advance && noise |=> !v2_reg)
        else $error("noisy sample passed the length test");

    // a word only appears at stage 3 if stage 2 held one
    a_stage3_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("stage 3 valid without stage 2 word");

    // pressure follows the contact flag in every result
    a_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[43:33] == (m_axis_tdata[32] ? PressFull : 11'd0)))
        else $error("pressure does not match touching");

    // reported height stays inside its clamp range
    a_distance: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[57:44]) >= $signed(HeightBottom[13:0])
                           && $signed(m_axis_tdata[57:44]) <= $signed(HeightTop[13:0])))
        else $error("distance outside clamp range");

    // tilt magnitudes never exceed ninety degrees
    a_tilt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[65:58]) >= -8'sd90
                           && $signed(m_axis_tdata[65:58]) <= 8'sd90
                           && $signed(m_axis_tdata[73:66]) >= -8'sd90
                           && $signed(m_axis_tdata[73:66]) <= 8'sd90))
        else $error("tilt outside range");

endmodule
